@@ rtl/rbw_pkg.sv @@
// ----------------------------------------------------------------------------
// rbw_pkg
// Types and constants shared by the ring buffer with parked writer and reader.
// ----------------------------------------------------------------------------
package rbw_pkg;

  localparam int unsigned DEPTH     = 256;
  localparam int unsigned MAX_BLOCK = 8;
  localparam int unsigned NLANES    = MAX_BLOCK;
  localparam int unsigned LANE_W    = $clog2(NLANES);
  localparam int unsigned ADDR_W    = $clog2(DEPTH);
  localparam int unsigned POS_W     = ADDR_W + 1;
  localparam int unsigned ROWS      = DEPTH / NLANES;
  localparam int unsigned ROW_W     = $clog2(ROWS);
  localparam int unsigned CAP_W     = 9;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned STAT_W    = 3;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_WRITTEN = 3'd0,
    ST_READ    = 3'd1,
    ST_WPARK   = 3'd2,
    ST_RPARK   = 3'd3,
    ST_WDONE   = 3'd4,
    ST_RDONE   = 3'd5,
    ST_BUSY    = 3'd6,
    ST_LARGE   = 3'd7
  } rbw_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_XA,
    S_XB,
    S_XW,
    S_EMIT
  } rbw_state_e;

  // one bank access
  typedef struct packed {
    logic              en;
    logic              we;
    logic [ROW_W-1:0]  row;
    logic [LANE_W-1:0] slot;
    logic [7:0]        wbyte;
  } rbw_lane_cmd_t;

  // registered bank read, tagged with its byte slot in the block
  typedef struct packed {
    logic              vld;
    logic [LANE_W-1:0] slot;
    logic [7:0]        rbyte;
  } rbw_lane_rd_t;

endpackage

@@ rtl/rbw_if.sv @@
// ----------------------------------------------------------------------------
// rbw_req_if / rbw_rsp_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface rbw_req_if import rbw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [CNT_W-1:0]  count;
  logic [DATA_W-1:0] block_data;

  modport source (output valid, kind, count, block_data, input ready);
  modport sink   (input valid, kind, count, block_data, output ready);
endinterface

interface rbw_rsp_if import rbw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [DATA_W-1:0] result_data;
  logic [CNT_W-1:0]  result_count;
  logic [CAP_W-1:0]  fill_after;
  logic              last;

  modport source (output valid, status, result_data, result_count, fill_after, last,
                  input ready);
  modport sink   (input valid, status, result_data, result_count, fill_after, last,
                  output ready);
endinterface

@@ rtl/rbw_lane.sv @@
// ----------------------------------------------------------------------------
// rbw_lane
// One byte bank of the ring storage: single port, registered read.
// ----------------------------------------------------------------------------
module rbw_lane import rbw_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rbw_lane_cmd_t cmd_i,
  output rbw_lane_rd_t  rd_o
);

  logic [7:0]        mem [ROWS];
  logic [7:0]        rbyte_q;
  logic [LANE_W-1:0] slot_q;
  logic              vld_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.en && cmd_i.we) begin
      mem[cmd_i.row] <= cmd_i.wbyte;
    end
    if (cmd_i.en && !cmd_i.we) begin
      rbyte_q <= mem[cmd_i.row];
      slot_q  <= cmd_i.slot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= cmd_i.en && !cmd_i.we;
    end
  end

  assign rd_o.vld   = vld_q;
  assign rd_o.slot  = slot_q;
  assign rd_o.rbyte = rbyte_q;

endmodule

@@ rtl/rbw_merge.sv @@
// ----------------------------------------------------------------------------
// rbw_merge
// Gathers the bytes the banks return into one block word, over up to two
// bank phases.
// ----------------------------------------------------------------------------
module rbw_merge import rbw_pkg::*; (
  input  logic                      clk_i,
  input  rbw_lane_rd_t [NLANES-1:0] rd_i,
  input  logic                      clr_i,
  input  logic                      hold_i,
  output logic [DATA_W-1:0]         word_o
);

  logic [DATA_W-1:0] acc_q;
  logic [DATA_W-1:0] word;

  always_comb begin
    word = acc_q;
    for (int l = 0; l < int'(NLANES); l++) begin
      if (rd_i[l].vld) begin
        word[8*rd_i[l].slot +: 8] = rd_i[l].rbyte;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_i) begin
      acc_q <= '0;
    end else if (hold_i) begin
      acc_q <= word;
    end
  end

  assign word_o = word;

endmodule

@@ rtl/block_ring_buffer_with_waiters.sv @@
// ----------------------------------------------------------------------------
// block_ring_buffer_with_waiters
// Byte ring buffer moving blocks of 1..8 bytes, with one parked writer and
// one parked reader.
// ----------------------------------------------------------------------------
// Storage is eight single-port byte banks, interleaved by address; a block is
// stored or fetched in bank phase S_XA, plus phase S_XB when it crosses the
// wrap point (bytes before and after the wrap share banks). A write or read
// that is carried out runs S_XA, S_XB if it wraps, S_XW and S_EMIT; a parked
// request released by it runs the same states for the second result. Refusals
// and parking go from S_IDLE straight to S_EMIT. The next request is taken
// once the last result is in the output register, even if it has not yet been
// taken. Storage is not cleared by reset: bytes never written read back as
// anything. Capacity must be written only while the block is idle; the block
// does not enforce this. 0 acts as 1 and values above 256 as 256.
// ----------------------------------------------------------------------------
module block_ring_buffer_with_waiters import rbw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  rbw_req_if.sink          req_i,
  rbw_rsp_if.source        rsp_o,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_data_i
);

  rbw_state_e        state_q, state_d;
  logic [CAP_W-1:0]  cap_q, fill_q, free_room;
  logic [ADDR_W-1:0] wr_pos_q, rd_pos_q;

  logic              ww_q, rw_q;
  logic [CNT_W-1:0]  wwc_q, rwc_q;
  logic [DATA_W-1:0] wwd_q;

  // block being moved
  logic              x_rd_q, x_sec_q;
  logic [CNT_W-1:0]  x_n_q, x_lena_q;
  logic [DATA_W-1:0] x_data_q;
  logic              sec_pend_q;

  // staged result
  rbw_status_e       res_stat_q;
  logic [DATA_W-1:0] res_data_q;
  logic [CNT_W-1:0]  res_cnt_q;
  logic [CAP_W-1:0]  res_fill_q;
  logic              res_last_q;

  // output register
  logic              out_vld_q;
  rbw_status_e       out_stat_q;
  logic [DATA_W-1:0] out_data_q;
  logic [CNT_W-1:0]  out_cnt_q;
  logic [CAP_W-1:0]  out_fill_q;
  logic              out_last_q;

  logic accept, out_load, acc_clr, acc_hold, sec_go;
  logic too_large, busy, fits;

  logic [ADDR_W-1:0] p;
  logic [POS_W-1:0]  p_ext, end_a;
  logic [CAP_W-1:0]  room_a;
  logic [CNT_W-1:0]  lena;
  logic [ADDR_W-1:0] new_pos;

  rbw_lane_cmd_t [NLANES-1:0] cmd_a, cmd_b, cmd;
  rbw_lane_rd_t  [NLANES-1:0] rd;
  logic [DATA_W-1:0]          word;

  assign free_room = (fill_q >= cap_q) ? '0 : cap_q - fill_q;

  // request checks
  always_comb begin
    too_large = (req_i.count == '0) || (req_i.count > CNT_W'(MAX_BLOCK)) ||
                (CAP_W'(req_i.count) > cap_q);
    busy      = (req_i.kind == KIND_READ) ? rw_q : ww_q;
    fits      = (req_i.kind == KIND_READ) ? (fill_q >= CAP_W'(req_i.count))
                                          : (free_room >= CAP_W'(req_i.count));
  end

  // first bank phase: bytes up to the wrap point
  always_comb begin
    logic [LANE_W-1:0] i;
    logic [POS_W-1:0]  addr;
    p      = x_rd_q ? rd_pos_q : wr_pos_q;
    p_ext  = POS_W'(p);
    room_a = cap_q - CAP_W'(p_ext);
    if (CAP_W'(p_ext) >= cap_q) begin
      lena = CNT_W'(1);
    end else if (CAP_W'(x_n_q) <= room_a) begin
      lena = x_n_q;
    end else begin
      lena = room_a[CNT_W-1:0];
    end
    end_a = p_ext + POS_W'(x_n_q);
    if (x_n_q > lena) begin
      new_pos = ADDR_W'(x_n_q - lena);
    end else if (CAP_W'(end_a) >= cap_q) begin
      new_pos = '0;
    end else begin
      new_pos = end_a[ADDR_W-1:0];
    end
    for (int b = 0; b < int'(NLANES); b++) begin
      i              = LANE_W'(b) - p[LANE_W-1:0];
      addr           = p_ext + POS_W'(i);
      cmd_a[b].en    = CNT_W'(i) < lena;
      cmd_a[b].we    = !x_rd_q;
      cmd_a[b].row   = addr[ADDR_W-1:LANE_W];
      cmd_a[b].slot  = i;
      cmd_a[b].wbyte = x_data_q[8*i +: 8];
    end
  end

  // second bank phase: bytes after the wrap, from address 0
  always_comb begin
    logic [CNT_W:0] j;
    for (int b = 0; b < int'(NLANES); b++) begin
      j              = {1'b0, x_lena_q} + (CNT_W+1)'(b);
      cmd_b[b].en    = j < {1'b0, x_n_q};
      cmd_b[b].we    = !x_rd_q;
      cmd_b[b].row   = '0;
      cmd_b[b].slot  = j[LANE_W-1:0];
      cmd_b[b].wbyte = x_data_q[8*j[LANE_W-1:0] +: 8];
    end
  end

  // a parked request of the other kind that can now complete
  assign sec_go = !x_sec_q &&
                  (x_rd_q ? (ww_q && free_room >= CAP_W'(wwc_q))
                          : (rw_q && fill_q >= CAP_W'(rwc_q)));

  for (genvar g = 0; g < int'(NLANES); g++) begin : g_lane
    rbw_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd[g]),
      .rd_o   (rd[g])
    );
  end

  rbw_merge u_merge (
    .clk_i  (clk_i),
    .rd_i   (rd),
    .clr_i  (acc_clr),
    .hold_i (acc_hold),
    .word_o (word)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (!too_large && !busy && fits) ? S_XA : S_EMIT;
        end
      end
      S_XA:   state_d = (x_n_q > lena) ? S_XB : S_XW;
      S_XB:   state_d = S_XW;
      S_XW:   state_d = S_EMIT;
      S_EMIT: begin
        if (out_load) begin
          state_d = sec_pend_q ? S_XA : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_i.ready = 1'b0;
    acc_clr     = 1'b0;
    acc_hold    = 1'b0;
    out_load    = 1'b0;
    cmd         = '0;
    unique case (state_q)
      S_IDLE: req_i.ready = 1'b1;
      S_XA: begin
        cmd     = cmd_a;
        acc_clr = 1'b1;
      end
      S_XB: begin
        cmd      = cmd_b;
        acc_hold = 1'b1;
      end
      S_XW:   ;
      S_EMIT: out_load = !out_vld_q || rsp_o.ready;
      default: ;
    endcase
  end

  assign accept = req_i.valid && req_i.ready;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cap_q      <= CAP_W'(DEPTH);
      fill_q     <= '0;
      wr_pos_q   <= '0;
      rd_pos_q   <= '0;
      ww_q       <= 1'b0;
      wwc_q      <= '0;
      rw_q       <= 1'b0;
      rwc_q      <= '0;
      sec_pend_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_data_i == '0) begin
          cap_q <= CAP_W'(1);
        end else if (cfg_data_i > CAP_W'(DEPTH)) begin
          cap_q <= CAP_W'(DEPTH);
        end else begin
          cap_q <= cfg_data_i;
        end
      end
      if (accept && !too_large && !busy && !fits) begin
        if (req_i.kind == KIND_READ) begin
          rw_q  <= 1'b1;
          rwc_q <= req_i.count;
        end else begin
          ww_q  <= 1'b1;
          wwc_q <= req_i.count;
        end
      end
      if (state_q == S_XA) begin
        if (x_rd_q) begin
          rd_pos_q <= new_pos;
          fill_q   <= fill_q - CAP_W'(x_n_q);
        end else begin
          wr_pos_q <= new_pos;
          fill_q   <= fill_q + CAP_W'(x_n_q);
        end
      end
      if (state_q == S_XW) begin
        sec_pend_q <= sec_go;
        if (sec_go) begin
          if (x_rd_q) begin
            ww_q  <= 1'b0;
            wwc_q <= '0;
          end else begin
            rw_q  <= 1'b0;
            rwc_q <= '0;
          end
        end
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_fill_q <= fill_q;
      res_last_q <= 1'b1;
      res_data_q <= '0;
      res_cnt_q  <= '0;
      if (too_large) begin
        res_stat_q <= ST_LARGE;
      end else if (busy) begin
        res_stat_q <= ST_BUSY;
      end else if (!fits) begin
        res_stat_q <= (req_i.kind == KIND_READ) ? ST_RPARK : ST_WPARK;
        if (req_i.kind == KIND_WRITE) begin
          wwd_q <= req_i.block_data;
        end
      end
      x_rd_q   <= req_i.kind;
      x_n_q    <= req_i.count;
      x_data_q <= req_i.block_data;
      x_sec_q  <= 1'b0;
    end
    if (state_q == S_XA) begin
      x_lena_q <= lena;
    end
    if (state_q == S_XW) begin
      if (x_sec_q) begin
        res_stat_q <= x_rd_q ? ST_RDONE : ST_WDONE;
      end else begin
        res_stat_q <= x_rd_q ? ST_READ : ST_WRITTEN;
      end
      res_data_q <= x_rd_q ? word : '0;
      res_cnt_q  <= x_n_q;
      res_fill_q <= fill_q;
      res_last_q <= !sec_go;
      if (sec_go) begin
        x_rd_q   <= !x_rd_q;
        x_n_q    <= x_rd_q ? wwc_q : rwc_q;
        x_data_q <= wwd_q;
        x_sec_q  <= 1'b1;
      end
    end
    if (out_load) begin
      out_stat_q <= res_stat_q;
      out_data_q <= res_data_q;
      out_cnt_q  <= res_cnt_q;
      out_fill_q <= res_fill_q;
      out_last_q <= res_last_q;
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.status       = out_stat_q;
  assign rsp_o.result_data  = out_data_q;
  assign rsp_o.result_count = out_cnt_q;
  assign rsp_o.fill_after   = out_fill_q;
  assign rsp_o.last         = out_last_q;

  // second bank phase only ever follows the first
  a_xb_after_xa: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_XB) |-> ($past(state_q) == S_XA))
    else $error("bank phase B without phase A");

  a_read_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_XA && x_rd_q) |-> (fill_q >= CAP_W'(x_n_q)))
    else $error("block read with too few bytes present");

  a_write_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_XA && !x_rd_q) |-> (free_room >= CAP_W'(x_n_q)))
    else $error("block write without room");

  a_first_of_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.last) |->
      (rsp_o.status == ST_WRITTEN || rsp_o.status == ST_READ))
    else $error("non-final beat that is not a direct write or read");

endmodule

@@ bench/rbw_ring_checker.sv @@
// ----------------------------------------------------------------------------
// rbw_ring_checker
// Watches the request, result and capacity ports of the ring buffer, keeps
// its own image of the ring and the parked writer and reader, and checks
// every result beat against the oldest predicted one.
// ----------------------------------------------------------------------------
module rbw_ring_checker import rbw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  rbw_req_if               req,
  rbw_rsp_if               rsp,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_data_i,
  output int unsigned      err_count_o,
  output int unsigned      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    rbw_status_e       status;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  count;
    logic [CAP_W-1:0]  fill;
    logic              last;
  } ring_result_t;

  logic [7:0]        ring_mem [DEPTH];
  int unsigned       wr_pos;
  int unsigned       rd_pos;
  int unsigned       fill;
  logic              wait_wr;
  int unsigned       wait_wr_cnt;
  logic [DATA_W-1:0] wait_wr_data;
  logic              wait_rd;
  int unsigned       wait_rd_cnt;
  logic [CAP_W-1:0]  cap_reg;

  ring_result_t      due_results [$];
  int unsigned       n_err;
  int unsigned       n_due;

  assign err_count_o = n_err;
  assign pending_o   = n_due;

  function automatic int unsigned cap_now();
    if (cap_reg == '0) return 1;
    if (cap_reg > DEPTH) return DEPTH;
    return cap_reg;
  endfunction

  function automatic int unsigned room_now();
    return (fill >= cap_now()) ? 0 : cap_now() - fill;
  endfunction

  // a position past the end of a shrunk ring drops to 0 on its next step
  function automatic int unsigned pos_after(input int unsigned p);
    return (p + 1 >= cap_now()) ? 0 : p + 1;
  endfunction

  function automatic ring_result_t mk_result(input rbw_status_e st,
                                             input logic [DATA_W-1:0] d,
                                             input int unsigned c);
    ring_result_t r;
    r.status = st;
    r.data   = d;
    r.count  = c[CNT_W-1:0];
    r.fill   = fill[CAP_W-1:0];
    r.last   = 1'b0;
    return r;
  endfunction

  task automatic store_bytes(input logic [DATA_W-1:0] d, input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      ring_mem[wr_pos % DEPTH] = d[8*i +: 8];
      wr_pos = pos_after(wr_pos);
    end
    fill = fill + n;
  endtask

  task automatic fetch_bytes(input int unsigned n, output logic [DATA_W-1:0] v);
    v = '0;
    for (int unsigned i = 0; i < n; i++) begin
      v[8*i +: 8] = ring_mem[rd_pos % DEPTH];
      rd_pos = pos_after(rd_pos);
    end
    fill = (fill >= n) ? fill - n : 0;
  endtask

  task automatic apply_block_request(input logic kind, input logic [CNT_W-1:0] cnt,
                                     input logic [DATA_W-1:0] d);
    ring_result_t      res [2];
    int unsigned       n;
    int unsigned       c;
    int unsigned       held;
    logic [DATA_W-1:0] v;
    n = 0;
    c = cnt;
    if (c == 0 || c > MAX_BLOCK || c > cap_now()) begin
      res[n++] = mk_result(ST_LARGE, '0, 0);
    end else if (kind == KIND_WRITE) begin
      if (wait_wr) begin
        res[n++] = mk_result(ST_BUSY, '0, 0);
      end else if (room_now() >= c) begin
        store_bytes(d, c);
        res[n++] = mk_result(ST_WRITTEN, '0, c);
        if (wait_rd && fill >= wait_rd_cnt) begin
          held = wait_rd_cnt;
          fetch_bytes(held, v);
          wait_rd     = 1'b0;
          wait_rd_cnt = 0;
          res[n++] = mk_result(ST_RDONE, v, held);
        end
      end else begin
        wait_wr      = 1'b1;
        wait_wr_cnt  = c;
        wait_wr_data = d;
        res[n++] = mk_result(ST_WPARK, '0, 0);
      end
    end else begin
      if (wait_rd) begin
        res[n++] = mk_result(ST_BUSY, '0, 0);
      end else if (fill >= c) begin
        fetch_bytes(c, v);
        res[n++] = mk_result(ST_READ, v, c);
        if (wait_wr && room_now() >= wait_wr_cnt) begin
          held = wait_wr_cnt;
          store_bytes(wait_wr_data, held);
          wait_wr     = 1'b0;
          wait_wr_cnt = 0;
          res[n++] = mk_result(ST_WDONE, '0, held);
        end
      end else begin
        wait_rd     = 1'b1;
        wait_rd_cnt = c;
        res[n++] = mk_result(ST_RPARK, '0, 0);
      end
    end
    res[n-1].last = 1'b1;
    for (int unsigned i = 0; i < n; i++) due_results.push_back(res[i]);
  endtask

  task automatic check_result();
    ring_result_t want;
    if (due_results.size() == 0) begin
      $display("%0t: unexpected result beat: status %0d data %h count %0d fill %0d last %b",
               $time, rsp.status, rsp.result_data, rsp.result_count, rsp.fill_after,
               rsp.last);
      n_err++;
    end else begin
      want = due_results.pop_front();
      if (rsp.status !== want.status || rsp.result_data !== want.data ||
          rsp.result_count !== want.count || rsp.fill_after !== want.fill ||
          rsp.last !== want.last) begin
        $display("%0t: result mismatch: expected status %0d data %h count %0d fill %0d last %b",
                 $time, want.status, want.data, want.count, want.fill, want.last);
        $display("%0t:                    actual status %0d data %h count %0d fill %0d last %b",
                 $time, rsp.status, rsp.result_data, rsp.result_count, rsp.fill_after,
                 rsp.last);
        n_err++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < DEPTH; i++) ring_mem[i] = 8'h00;
      wr_pos       = 0;
      rd_pos       = 0;
      fill         = 0;
      wait_wr      = 1'b0;
      wait_wr_cnt  = 0;
      wait_wr_data = '0;
      wait_rd      = 1'b0;
      wait_rd_cnt  = 0;
      cap_reg      = CAP_W'(DEPTH);
      due_results.delete();
      n_err        = 0;
      n_due        = 0;
    end else begin
      if (cfg_we_i) cap_reg = cfg_data_i;
      if (rsp.valid && rsp.ready) check_result();
      if (req.valid && req.ready) apply_block_request(req.kind, req.count, req.block_data);
      n_due = due_results.size();
    end
  end

endmodule

@@ bench/tb_block_ring_buffer_with_waiters.sv @@
// ----------------------------------------------------------------------------
// tb_block_ring_buffer_with_waiters
// Drives block writes and reads into the ring buffer under several capacity
// settings and handshake idling patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_block_ring_buffer_with_waiters;
  import rbw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS = 100;
  localparam int unsigned N_PHASES    = 10;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_data;
  int unsigned      err_count;
  int unsigned      pending;

  rbw_req_if req_if ();
  rbw_rsp_if rsp_if ();

  block_ring_buffer_with_waiters i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  rbw_ring_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_if),
    .rsp         (rsp_if),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  int unsigned cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_block_ring_buffer_with_waiters failed");
      $finish;
    end
  end

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  // long output hold-off: main process bumps hold_go, receiver counts it out
  int unsigned hold_len  = 0;
  int unsigned hold_go   = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_go != hold_seen) begin
      hold_seen    <= hold_go;
      hold_left    <= hold_len;
      rsp_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // coarse image of fill and parked requests, only to steer the stimulus
  int unsigned      sh_fill;
  logic [CAP_W-1:0] sh_cap;
  logic             sh_wpark;
  int unsigned      sh_wcnt;
  logic             sh_rpark;
  int unsigned      sh_rcnt;
  int unsigned      n_sent;
  int unsigned      n_cfg;

  function automatic int unsigned sh_ce();
    if (sh_cap == '0) return 1;
    if (sh_cap > DEPTH) return DEPTH;
    return sh_cap;
  endfunction

  function automatic int unsigned sh_room();
    return (sh_fill >= sh_ce()) ? 0 : sh_ce() - sh_fill;
  endfunction

  function automatic int unsigned sh_maxc();
    return (sh_ce() < MAX_BLOCK) ? sh_ce() : MAX_BLOCK;
  endfunction

  task automatic track_request(input logic kind, input int unsigned c);
    if (c == 0 || c > MAX_BLOCK || c > sh_ce()) begin
      // refused
    end else if (kind == KIND_WRITE) begin
      if (!sh_wpark) begin
        if (sh_room() >= c) begin
          sh_fill += c;
          if (sh_rpark && sh_fill >= sh_rcnt) begin
            sh_fill -= sh_rcnt;
            sh_rpark = 1'b0;
          end
        end else begin
          sh_wpark = 1'b1;
          sh_wcnt  = c;
        end
      end
    end else if (!sh_rpark) begin
      if (sh_fill >= c) begin
        sh_fill -= c;
        if (sh_wpark && sh_room() >= sh_wcnt) begin
          sh_fill += sh_wcnt;
          sh_wpark = 1'b0;
        end
      end else begin
        sh_rpark = 1'b1;
        sh_rcnt  = c;
      end
    end
  endtask

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_req(input logic kind, input int unsigned c,
                          input logic [DATA_W-1:0] d);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.kind       <= kind;
    req_if.count      <= c[CNT_W-1:0];
    req_if.block_data <= d;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    track_request(kind, c);
    n_sent++;
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] v);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    sh_cap   = v;
    n_cfg++;
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 47; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 47; end
      default: begin idle_pct = 6; stall_pct = 6; end
    endcase
  endtask

  function automatic logic [DATA_W-1:0] rand_bytes();
    return {$urandom, $urandom};
  endfunction

  // mostly well-formed blocks; never lets a writer and a reader park together
  task automatic random_req();
    logic        k;
    int unsigned c;
    int unsigned maxc;
    int unsigned pick;
    k    = 1'($urandom_range(1));
    maxc = sh_maxc();
    if ($urandom_range(99) < 12) begin
      pick = $urandom_range(2);
      if (pick == 0) c = 0;
      else if (pick == 1 || maxc == MAX_BLOCK) c = $urandom_range(15, MAX_BLOCK + 1);
      else c = $urandom_range(MAX_BLOCK, maxc + 1);
    end else begin
      c = $urandom_range(maxc, 1);
      if (k == KIND_READ && sh_wpark && !sh_rpark && c > sh_fill) c = sh_fill;
      if (k == KIND_WRITE && sh_rpark && !sh_wpark && c > sh_room()) c = sh_room();
    end
    send_req(k, c, rand_bytes());
  endtask

  int unsigned      phase_caps [N_PHASES] = '{256, 1, 8, 3, 0, 511, 5, 16, 2, 64};
  logic [CAP_W-1:0] next_cap;

  initial begin
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_data          = '0;
    req_if.valid      = 1'b0;
    req_if.kind       = KIND_WRITE;
    req_if.count      = '0;
    req_if.block_data = '0;
    sh_fill  = 0;
    sh_cap   = CAP_W'(DEPTH);
    sh_wpark = 1'b0;
    sh_wcnt  = 0;
    sh_rpark = 1'b0;
    sh_rcnt  = 0;
    n_sent   = 0;
    n_cfg    = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // fill the whole ring once and drain it, so every byte has been written
    set_idling(3);
    repeat (DEPTH / MAX_BLOCK) send_req(KIND_WRITE, MAX_BLOCK, rand_bytes());
    repeat (DEPTH / MAX_BLOCK) send_req(KIND_READ, MAX_BLOCK, rand_bytes());

    set_idling(0);
    send_req(KIND_WRITE, 8, '1);
    send_req(KIND_WRITE, 1, '0);
    send_req(KIND_READ, 8, '0);
    send_req(KIND_READ, 2, '0);           // not enough data: reader parks
    send_req(KIND_READ, 1, '0);           // second reader refused
    send_req(KIND_WRITE, 1, 64'hA5);      // releases the parked reader
    send_req(KIND_WRITE, 0, rand_bytes());
    send_req(KIND_READ, 9, '0);
    send_req(KIND_WRITE, 15, '1);
    set_capacity('0);                     // acts as 1
    send_req(KIND_WRITE, 2, rand_bytes());
    send_req(KIND_WRITE, 1, rand_bytes());
    send_req(KIND_WRITE, 1, rand_bytes());
    send_req(KIND_WRITE, 1, rand_bytes());
    send_req(KIND_READ, 1, '0);
    send_req(KIND_READ, 1, '0);
    set_capacity(CAP_W'(8));
    send_req(KIND_WRITE, 8, rand_bytes());
    send_req(KIND_WRITE, 3, rand_bytes());
    send_req(KIND_READ, 8, '0);
    set_capacity(CAP_W'(DEPTH));
    send_req(KIND_WRITE, 8, rand_bytes());
    set_capacity(CAP_W'(4));              // fill now above the capacity
    send_req(KIND_WRITE, 1, rand_bytes());
    send_req(KIND_READ, 4, '0);
    send_req(KIND_READ, 4, '0);
    send_req(KIND_READ, 4, '0);

    for (int unsigned p = 0; p < N_PHASES; p++) begin
      next_cap = CAP_W'(phase_caps[p]);
      if ((sh_wpark || sh_rpark) && next_cap < MAX_BLOCK) next_cap = CAP_W'(MAX_BLOCK);
      set_capacity(next_cap);
      set_idling(p % 4);
      if (p == 4) begin
        hold_len = HOLD_CYCLES;
        hold_go++;
      end
      repeat (PHASE_ITEMS) random_req();
    end

    // clear parked requests and the ring, then drive into a deadlock
    set_idling(3);
    while (sh_wpark) send_req(KIND_READ, (sh_fill < sh_maxc()) ? sh_fill : sh_maxc(), '0);
    while (sh_rpark) send_req(KIND_WRITE, (sh_room() < sh_maxc()) ? sh_room() : sh_maxc(),
                              rand_bytes());
    set_capacity(CAP_W'(4));
    while (sh_fill > 0) send_req(KIND_READ, (sh_fill < 4) ? sh_fill : 4, '0);
    send_req(KIND_WRITE, 3, rand_bytes());
    send_req(KIND_WRITE, 2, rand_bytes());
    send_req(KIND_READ, 4, '0);
    send_req(KIND_WRITE, 1, rand_bytes());
    send_req(KIND_READ, 1, '0);
    send_req(KIND_WRITE, 9, rand_bytes());

    req_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("%0d request beats over %0d capacity settings, with idling on both sides,",
             n_sent, n_cfg);
    $display("a long output hold-off, parked writers and readers, and a final deadlock");
    if (err_count == 0) begin
      $display("tb_block_ring_buffer_with_waiters passed");
    end else begin
      $display("tb_block_ring_buffer_with_waiters failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/rbw_pkg.sv
rtl/rbw_if.sv
rtl/rbw_lane.sv
rtl/rbw_merge.sv
rtl/block_ring_buffer_with_waiters.sv
bench/rbw_ring_checker.sv
bench/tb_block_ring_buffer_with_waiters.sv
